>>> sv/pcab_pkg.sv
// Shared constants, codes and field widths for the configuration access bridge.
package pcab_pkg;

    // Storage depth and the number of words an 8-bit byte offset can reach.
    localparam int PCAB_CONFIG_WORDS = 64;
    localparam int PCAB_REACH_WORDS  = 64;

    // Field widths of one access beat and one result beat.
    localparam int DEVFN_W  = 8;
    localparam int OFFSET_W = 8;
    localparam int SIZE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int S_TDATA_W = 56;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINK_UP = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAR0_FIX = 1'd1;

    // Access kinds.
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Access sizes in bytes.
    localparam logic [SIZE_W-1:0] SIZE_BYTE = 3'd1;
    localparam logic [SIZE_W-1:0] SIZE_HALF = 3'd2;
    localparam logic [SIZE_W-1:0] SIZE_WORD = 3'd4;

    // Completion status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_SIZE  = 2'd2;

    // BAR0 handling constants.
    localparam logic [OFFSET_W-1:0] BAR0_OFFSET     = 8'h10;
    localparam logic [WORD_W-1:0]   BAR0_SUBSTITUTE = 32'h0000_ffff;
    localparam logic [WORD_W-1:0]   ALL_ONES        = 32'hffff_ffff;
    localparam logic [WORD_W-1:0]   BYTE_MASK       = 32'h0000_00ff;
    localparam logic [WORD_W-1:0]   HALF_MASK       = 32'h0000_ffff;

endpackage

>>> sv/pcab_cfg_mem.sv
// Configuration word store: synchronous memory with per-word valid bits.
module pcab_cfg_mem
    import pcab_pkg::*;
#(
    parameter int WORDS = PCAB_REACH_WORDS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(WORDS)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_word,
    input  logic                     wr_en,
    input  logic [$clog2(WORDS)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_word
);

    logic [WORD_W-1:0] mem [WORDS];
    logic [WORDS-1:0]  valid_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // Word array: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits stand in for clearing the array; reset empties them all at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A word never written since reset reads as zero.
    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> sv/pcab_lane.sv
// Byte-lane merge for writes and lane extraction for reads on one config word.
module pcab_lane
    import pcab_pkg::*;
(
    input  logic [WORD_W-1:0] word_in,
    input  logic [1:0]        lane_sel,
    input  logic [SIZE_W-1:0] size,
    input  logic [WORD_W-1:0] wr_value,
    output logic [WORD_W-1:0] word_merged,
    output logic [WORD_W-1:0] rd_lane
);

    logic [4:0] byte_shift;
    logic [4:0] half_shift;

    assign byte_shift = {lane_sel, 3'b000};
    assign half_shift = {lane_sel[1], 4'b0000};

    // Select the lane by size; unaligned halfwords use only offset bit 1.
    always_comb begin
        case (size)
            SIZE_BYTE: begin
                word_merged = (word_in & ~(BYTE_MASK << byte_shift))
                            | ((wr_value & BYTE_MASK) << byte_shift);
                rd_lane     = (word_in >> byte_shift) & BYTE_MASK;
            end
            SIZE_HALF: begin
                word_merged = (word_in & ~(HALF_MASK << half_shift))
                            | ((wr_value & HALF_MASK) << half_shift);
                rd_lane     = (word_in >> half_shift) & HALF_MASK;
            end
            default: begin
                word_merged = wr_value;
                rd_lane     = word_in;
            end
        endcase
    end

endmodule

>>> sv/pci_config_access_bridge.sv
// Top level of the configuration-space access bridge for one PCI device.
//
// Access beats arrive on the s_ channel: s_tuser carries the access kind
// (read or write), s_tdata the device/function, byte offset, size and write
// data. Every beat yields exactly one completion beat on the m_ channel with
// the status in m_tuser and the right-aligned read data in m_tdata.
// Two registers on the cfg_ channel set link-up and the BAR0 workaround;
// the user must write them only while no access is in flight; the bridge does not enforce this.
//
// On acceptance the synchronous read of the addressed word is launched;
// in the execute state that follows, the word is merged and written back
// and the output register is loaded. No beat is accepted in the execute
// state, so a new beat is taken only after the last one has executed.
// The completion register holds its beat while m_tready is low; a new
// access is accepted only when that register is empty or being drained.
// Reset empties the word store through per-word valid bits, so it reads as
// all zeros at once with no clearing pass, and clears the BAR0 state and
// both registers.
module pci_config_access_bridge
    import pcab_pkg::*;
#(
    parameter int CONFIG_WORDS = PCAB_CONFIG_WORDS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Access channel.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // devfn[7:0], offset[15:8],
                                              // access_size[18:16],
                                              // write_data[50:19], zero pad
    input  logic                   s_tuser,   // action
    // Completion channel.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [WORD_W-1:0]      m_tdata,   // read_data[31:0]
    output logic [STATUS_W-1:0]    m_tuser,   // status[1:0]
    // Register write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Only words reachable by an 8-bit offset need storage.
    localparam int MEM_WORDS = (CONFIG_WORDS < PCAB_REACH_WORDS) ? CONFIG_WORDS
                                                                 : PCAB_REACH_WORDS;
    localparam int AW = $clog2(MEM_WORDS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                  state_reg, state_next;
    logic                  link_up_reg;
    logic                  bar0_fix_reg;
    logic                  bar0_cached_reg;
    logic [WORD_W-1:0]     bar0_saved_reg;

    logic                  action_reg;
    logic [DEVFN_W-1:0]    devfn_reg;
    logic [OFFSET_W-1:0]   offset_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [WORD_W-1:0]     wdata_reg;

    logic                  m_valid_reg;
    logic [WORD_W-1:0]     m_data_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic                  s_accept;
    logic [OFFSET_W-1:0]   s_offset;
    logic [5:0]            widx;
    logic                  in_range;
    logic [WORD_W-1:0]     mem_word;
    logic [WORD_W-1:0]     cur_word;
    logic                  not_found;
    logic                  size_ok;
    logic                  access_ok;
    logic                  bar0_word;
    logic                  bar0_hit;
    logic [WORD_W-1:0]     wr_value;
    logic [WORD_W-1:0]     word_merged;
    logic [WORD_W-1:0]     rd_lane;
    logic                  mem_we;
    logic [STATUS_W-1:0]   status_next;
    logic [WORD_W-1:0]     rdata_next;

    assign s_offset  = s_tdata[15:8];
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Register writes; indexes outside the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_up_reg  <= 1'b0;
            bar0_fix_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LINK_UP:  link_up_reg  <= cfg_data[0];
                CFG_BAR0_FIX: bar0_fix_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: idle until a beat is accepted, then the execute state, then back to idle.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_accept) state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the access fields alongside the memory read.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            action_reg <= s_tuser;
            devfn_reg  <= s_tdata[7:0];
            offset_reg <= s_offset;
            size_reg   <= s_tdata[18:16];
            wdata_reg  <= s_tdata[50:19];
        end
    end

    assign widx     = offset_reg[7:2];
    assign in_range = 32'(widx) < 32'(MEM_WORDS);
    assign cur_word = in_range ? mem_word : '0;

    pcab_cfg_mem #(
        .WORDS (MEM_WORDS)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (s_offset[AW+1:2]),
        .rd_word (mem_word),
        .wr_en   (mem_we),
        .wr_addr (widx[AW-1:0]),
        .wr_word (word_merged)
    );

    // Checks in priority order: link, device number, then size.
    assign not_found = !link_up_reg || (devfn_reg != '0);
    assign size_ok   = size_reg inside {SIZE_BYTE, SIZE_HALF, SIZE_WORD};
    assign access_ok = !not_found && size_ok;

    // BAR0 workaround, if enabled: a full-word write other than all-ones is cached.
    assign bar0_word = (offset_reg == BAR0_OFFSET) && (size_reg == SIZE_WORD);
    assign bar0_hit  = (state_reg == S_EXEC) && access_ok && (action_reg == ACT_WRITE)
                       && bar0_fix_reg && bar0_word;
    assign wr_value  = (bar0_hit && (wdata_reg != ALL_ONES)) ? BAR0_SUBSTITUTE
                                                             : wdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar0_cached_reg <= 1'b0;
        end else if (bar0_hit) begin
            bar0_cached_reg <= (wdata_reg != ALL_ONES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bar0_saved_reg <= '0;
        end else if (bar0_hit && (wdata_reg != ALL_ONES)) begin
            bar0_saved_reg <= wdata_reg;
        end
    end

    pcab_lane u_lane (
        .word_in     (cur_word),
        .lane_sel    (offset_reg[1:0]),
        .size        (size_reg),
        .wr_value    (wr_value),
        .word_merged (word_merged),
        .rd_lane     (rd_lane)
    );

    assign mem_we = (state_reg == S_EXEC) && access_ok && (action_reg == ACT_WRITE)
                    && in_range;

    // Completion status and data.
    always_comb begin
        rdata_next = '0;
        if (not_found) begin
            status_next = STAT_NOT_FOUND;
        end else if (!size_ok) begin
            status_next = STAT_BAD_SIZE;
        end else begin
            status_next = STAT_OK;
            if (action_reg == ACT_READ) begin
                rdata_next = (bar0_word && bar0_cached_reg) ? bar0_saved_reg : rd_lane;
            end
        end
    end

    // Output register; it is always free when the execute cycle ends.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EXEC) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC) begin
            m_data_reg   <= rdata_next;
            m_status_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

    // Every accepted access has its completion waiting once the execute state has loaded the output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> ##2 m_tvalid)
        else $error("completion missing after accepted access");

    // Error completions never carry data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == '0))
        else $error("error completion with nonzero data");

    // The memory is written only during the execute cycle of a good write.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == S_EXEC) && !not_found && (action_reg == ACT_WRITE)))
        else $error("config word written outside a valid write");

    // The BAR0 cache is set only while the workaround is enabled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(bar0_cached_reg) |-> $past(bar0_fix_reg))
        else $error("BAR0 cache set with workaround disabled");

endmodule
